// ===== sv/gws_pkg.sv =====
// Shared package of the Gaussian window smoother: register map, fixed field widths,
// reset values and the job descriptor passed from the window control to the multiply stage.
// No dependencies.
package gws_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_HALF_WIDTH = 6;
	localparam int DEF_SAMPLE_BITS    = 16;

	// Fixed widths of the configuration registers.
	localparam int HW_W        = 3;
	localparam int COEF_W      = 17;
	localparam int NUM_COEF    = 7;
	localparam int CFG_INDEX_W = 4;

	// Positions in the window never exceed 12, so four bits hold a position or a distance.
	localparam int POS_W = 4;

	// Coefficients are Q1.16, so products carry 16 extra fraction bits.
	localparam int ROUND_SHIFT = 16;

	localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 17'd65536;

	// Register indices on the configuration channel.
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_CENTER = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_DIST6  = 4'd7;

	typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

	// Weight bank after reset: unit center weight, all other weights zero.
	localparam coef_bank_t COEF_BANK_RESET = {{(NUM_COEF-1)*COEF_W{1'b0}}, COEF_CENTER_RESET};

	// One smoothing job: which window position is the center, and whether it ends a sequence.
	typedef struct packed {
		logic [HW_W-1:0] center;
		logic            last;
	} job_t;

endpackage

// ===== sv/gws_ctrl.sv =====
// Window control of the Gaussian window smoother: holds the sample window and fill count,
// issues one smoothing job per output, and sequences the flush at a sequence end.
// Depends on gws_pkg.
module gws_ctrl #(
	parameter int MAX_HALF_WIDTH = gws_pkg::DEF_MAX_HALF_WIDTH,
	parameter int SAMPLE_BITS    = gws_pkg::DEF_SAMPLE_BITS,
	localparam int WIN_LEN       = 2 * MAX_HALF_WIDTH + 1
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [gws_pkg::HW_W-1:0]                 hw,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [SAMPLE_BITS-1:0]                   in_sample,
	input  logic                                     in_last,
	output logic                                     job_valid,
	output gws_pkg::job_t                            job,
	output logic [WIN_LEN-1:0][SAMPLE_BITS-1:0]      window,
	input  logic                                     job_ready
);

	logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] window_q, window_d, base_win, shifted;
	logic [gws_pkg::HW_W-1:0]            fill_q, fill_d, held, next_center;
	logic                                job_valid_q, job_valid_d;
	gws_pkg::job_t                       job_q, job_d;
	logic                                flush_q, flush_d;
	logic                                adv_ok, accept;

	always_comb begin
		adv_ok   = !job_valid_q || job_ready;
		in_ready = adv_ok && !flush_q;
		accept   = in_valid && in_ready;

		// A new sequence starts from an empty window once the final job of the old one leaves.
		base_win = (job_valid_q && job_q.last) ? '0 : window_q;
		shifted    = base_win;
		shifted[0] = in_sample;
		for (int i = 1; i < WIN_LEN; i++) begin
			shifted[i] = base_win[i-1];
		end

		held        = (fill_q < hw) ? fill_q : hw;
		next_center = job_q.center - gws_pkg::HW_W'(1);

		window_d    = window_q;
		fill_d      = fill_q;
		job_valid_d = job_valid_q;
		job_d       = job_q;
		flush_d     = flush_q;

		if (accept) begin
			window_d = shifted;
			if (!in_last) begin
				flush_d = 1'b0;
				if (fill_q < hw) begin
					fill_d      = fill_q + gws_pkg::HW_W'(1);
					job_valid_d = 1'b0;
				end else begin
					job_valid_d = 1'b1;
					job_d.center = hw;
					job_d.last   = 1'b0;
				end
			end else begin
				fill_d       = '0;
				job_valid_d  = 1'b1;
				job_d.center = held;
				job_d.last   = (held == '0);
				flush_d      = (held != '0);
			end
		end else if (job_valid_q && job_ready) begin
			if (flush_q) begin
				job_d.center = next_center;
				job_d.last   = (next_center == '0);
				flush_d      = (next_center != '0);
			end else begin
				job_valid_d = 1'b0;
				if (job_q.last) begin
					window_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			fill_q      <= '0;
			job_valid_q <= 1'b0;
			job_q       <= '0;
			flush_q     <= 1'b0;
		end else begin
			window_q    <= window_d;
			fill_q      <= fill_d;
			job_valid_q <= job_valid_d;
			job_q       <= job_d;
			flush_q     <= flush_d;
		end
	end

	assign job_valid = job_valid_q;
	assign job       = job_q;
	assign window    = window_q;

endmodule

// ===== sv/gws_mult.sv =====
// Multiply stage of the Gaussian window smoother: picks the weight of each window position
// from its distance to the job's center and registers all tap products.
// Depends on gws_pkg.
module gws_mult #(
	parameter int MAX_HALF_WIDTH = gws_pkg::DEF_MAX_HALF_WIDTH,
	parameter int SAMPLE_BITS    = gws_pkg::DEF_SAMPLE_BITS,
	localparam int WIN_LEN       = 2 * MAX_HALF_WIDTH + 1,
	localparam int PROD_W        = SAMPLE_BITS + gws_pkg::COEF_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [gws_pkg::HW_W-1:0]            hw,
	input  gws_pkg::coef_bank_t                 coefs,
	input  logic                                job_valid,
	output logic                                job_ready,
	input  gws_pkg::job_t                       job,
	input  logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] window,
	output logic                                prod_valid,
	output logic                                prod_last,
	output logic [WIN_LEN-1:0][PROD_W-1:0]      prods,
	input  logic                                prod_ready
);

	logic [WIN_LEN-1:0][PROD_W-1:0] prod_d, prod_s2;
	logic                           valid_s2, last_s2;
	logic                           adv;
	logic [gws_pkg::POS_W-1:0]      pos, cen, tap_dist;
	logic [gws_pkg::COEF_W-1:0]     coef;
	logic signed [PROD_W-1:0]       samp_ext, coef_ext;

	always_comb begin
		adv       = !valid_s2 || prod_ready;
		job_ready = adv;
		cen       = gws_pkg::POS_W'(job.center);
		prod_d    = '0;
		pos       = '0;
		tap_dist  = '0;
		coef      = '0;
		samp_ext  = '0;
		coef_ext  = '0;
		for (int p = 0; p < WIN_LEN; p++) begin
			pos      = gws_pkg::POS_W'(p);
			tap_dist = (pos >= cen) ? (pos - cen) : (cen - pos);
			// Taps beyond the half width get no weight.
			coef = (tap_dist <= gws_pkg::POS_W'(hw)) ?
				coefs[tap_dist[gws_pkg::HW_W-1:0]] : '0;
			samp_ext  = PROD_W'($signed(window[p]));
			coef_ext  = $signed(PROD_W'(coef));
			prod_d[p] = samp_ext * coef_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && job_valid) begin
			prod_s2 <= prod_d;
			last_s2 <= job.last;
		end
	end

	assign prod_valid = valid_s2;
	assign prod_last  = last_s2;
	assign prods      = prod_s2;

endmodule

// ===== sv/gws_reduce.sv =====
// Reduction stages of the Gaussian window smoother: partial sums of four taps, then the
// final sum, rounding to Q8.8, saturation and the output register of the result channel.
// Depends on gws_pkg.
module gws_reduce #(
	parameter int MAX_HALF_WIDTH = gws_pkg::DEF_MAX_HALF_WIDTH,
	parameter int SAMPLE_BITS    = gws_pkg::DEF_SAMPLE_BITS,
	localparam int WIN_LEN       = 2 * MAX_HALF_WIDTH + 1,
	localparam int PROD_W        = SAMPLE_BITS + gws_pkg::COEF_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           prod_valid,
	output logic                           prod_ready,
	input  logic                           prod_last,
	input  logic [WIN_LEN-1:0][PROD_W-1:0] prods,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [SAMPLE_BITS-1:0]         out_sample,
	output logic                           out_last
);

	localparam int GRP     = 4;
	localparam int NUM_GRP = (WIN_LEN + GRP - 1) / GRP;
	localparam int ACC_W   = PROD_W + $clog2(WIN_LEN) + 1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (gws_pkg::ROUND_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX    = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

	logic signed [NUM_GRP-1:0][ACC_W-1:0] part_d, part_s3;
	logic                                 valid_s3, last_s3;
	logic                                 adv3, adv4;
	logic signed [ACC_W-1:0]              total, rnd, sat;
	logic                                 out_valid_q, out_last_q;
	logic [SAMPLE_BITS-1:0]               out_sample_q;

	always_comb begin
		adv4       = !out_valid_q || out_ready;
		adv3       = !valid_s3 || adv4;
		prod_ready = adv3;
		part_d     = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < WIN_LEN) begin
					part_d[g] = $signed(part_d[g]) + ACC_W'($signed(prods[g * GRP + k]));
				end
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			total = total + $signed(part_s3[g]);
		end
		// Half an LSB added, then floor: ties round toward plus infinity.
		rnd = (total + ROUND_HALF) >>> gws_pkg::ROUND_SHIFT;
		if (rnd > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (rnd < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv3) begin
				valid_s3 <= prod_valid;
			end
			if (adv4) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && prod_valid) begin
			part_s3 <= part_d;
			last_s3 <= prod_last;
		end
		if (adv4 && valid_s3) begin
			out_sample_q <= sat[SAMPLE_BITS-1:0];
			out_last_q   <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;

endmodule

// ===== sv/gaussian_window_smoother.sv =====
// Gaussian window smoother: centered symmetric FIR smoothing of one sample sequence.
// Top level: configuration registers and the four-stage datapath.
// Depends on gws_pkg, gws_ctrl, gws_mult and gws_reduce.
//
// Use: samples arrive on the slave stream (s_tdata holds one signed Q8.8 sample, s_tlast
// marks the last sample of a sequence). Smoothed samples leave on the master stream in the
// same format, with m_tlast on the result for the last sample. Each sequence gives exactly
// one result per sample; the result for sample n is formed once sample n+half_width has
// arrived, and the sequence end flushes all pending results.
// Configuration: the cfg channel writes half_width (index 0) and the seven Q1.16 weights
// (indices 1 to 7); cfg_ready is always high. Write it only while the block is idle.
// Throughput: one sample per cycle unless a flush or back-pressure holds s_tready low.
// A sequence end keeps it low while its remaining flush jobs use the multiply stage.
// Path: the request completing a window reaches m_tvalid through the window register,
// product register, partial sum register and output register.
// Stalls: each stage holds its data while the next is full; back-pressure drops s_tready
// only once the whole pipeline is full; nothing is lost or repeated under back-pressure.
// Reset: arst_n clears the window, the fill count, the pipeline valids, half_width (0)
// and the weights (center 1.0, all others 0).
module gaussian_window_smoother #(
	parameter int MAX_HALF_WIDTH = gws_pkg::DEF_MAX_HALF_WIDTH,
	parameter int SAMPLE_BITS    = gws_pkg::DEF_SAMPLE_BITS,
	localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Sample requests.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [TDATA_W-1:0]                s_tdata,   // sample, then zero padding
	input  logic                              s_tlast,   // seq_end
	// Smoothed results.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [TDATA_W-1:0]                m_tdata,   // smoothed, then zero padding
	output logic                              m_tlast,   // out_last
	// Register writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gws_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gws_pkg::COEF_W-1:0]        cfg_data
);

	localparam int WIN_LEN = 2 * MAX_HALF_WIDTH + 1;
	localparam int PROD_W  = SAMPLE_BITS + gws_pkg::COEF_W;

	logic [gws_pkg::HW_W-1:0]            half_width_q, hw_eff;
	gws_pkg::coef_bank_t                 coef_q;
	logic [gws_pkg::HW_W-1:0]            coef_sel;
	logic                                cfg_write;

	logic                                job_valid, job_ready;
	gws_pkg::job_t                       job;
	logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] window;
	logic                                prod_valid, prod_ready, prod_last;
	logic [WIN_LEN-1:0][PROD_W-1:0]      prods;
	logic [SAMPLE_BITS-1:0]              out_sample;

	// Registers always writable; user must keep the block idle as they change; unchecked.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign coef_sel  = gws_pkg::HW_W'(cfg_index - gws_pkg::REG_COEF_CENTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
			coef_q       <= gws_pkg::COEF_BANK_RESET;
		end else if (cfg_write) begin
			// Writes to indices past the last weight are dropped.
			if (cfg_index == gws_pkg::REG_HALF_WIDTH) begin
				half_width_q <= cfg_data[gws_pkg::HW_W-1:0];
			end else if (cfg_index >= gws_pkg::REG_COEF_CENTER &&
					cfg_index <= gws_pkg::REG_COEF_DIST6) begin
				coef_q[coef_sel] <= cfg_data;
			end
		end
	end

	// A half width above what the window holds acts as the largest one.
	assign hw_eff = (half_width_q > gws_pkg::HW_W'(MAX_HALF_WIDTH)) ?
		gws_pkg::HW_W'(MAX_HALF_WIDTH) : half_width_q;

	gws_ctrl #(
		.MAX_HALF_WIDTH (MAX_HALF_WIDTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.hw        (hw_eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[SAMPLE_BITS-1:0]),
		.in_last   (s_tlast),
		.job_valid (job_valid),
		.job       (job),
		.window    (window),
		.job_ready (job_ready)
	);

	gws_mult #(
		.MAX_HALF_WIDTH (MAX_HALF_WIDTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.hw         (hw_eff),
		.coefs      (coef_q),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job),
		.window     (window),
		.prod_valid (prod_valid),
		.prod_last  (prod_last),
		.prods      (prods),
		.prod_ready (prod_ready)
	);

	gws_reduce #(
		.MAX_HALF_WIDTH (MAX_HALF_WIDTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod_last  (prod_last),
		.prods      (prods),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (out_sample),
		.out_last   (m_tlast)
	);

	assign m_tdata = TDATA_W'(out_sample);

	// A sequence end always leaves a job behind it, at least the result for its own sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> job_valid)
		else $error("sequence end accepted without a flush job");

	// Only the job centered on the newest sample may close a sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.last) |-> (job.center == '0))
		else $error("closing job not centered on the newest sample");

	// With no neighbors every non-final sample yields its own non-closing job at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast && hw_eff == '0) |=>
		(job_valid && !job.last && job.center == '0))
		else $error("zero half width sample did not issue its job");

	// A flush job that is not the closing one keeps new samples out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.center != '0 && $past(s_tvalid && s_tready && s_tlast)) |->
		!s_tready)
		else $error("sample taken during a flush");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gaussian_window_smoother: directed and random sample sequences
// are checked against a cycle-free predictor of the smoothing filter.
// Depends on gws_pkg and the gaussian_window_smoother RTL.
module testbench;

	import gws_pkg::*;

	localparam int SAMPLE_W  = DEF_SAMPLE_BITS;
	localparam int MAX_HW    = DEF_MAX_HALF_WIDTH;
	localparam int DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
	localparam int WIN_LEN   = 2 * MAX_HW + 1;

	localparam int IDLE_PCT      = 23;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 56;
	localparam int STEADY_PHASE  = 3;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int TIMEOUT_NS    = 2000000;

	// One sample request as it waits for the driver.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                seq_end;
	} sample_req_t;

	// One predicted output of the smoother.
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                is_last;
	} smooth_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata = '0;   // sample, then zero padding
	logic                   s_tlast = 1'b0; // seq_end
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [DATA_W-1:0]      m_tdata;        // smoothed, then zero padding
	logic                   m_tlast;        // out_last
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]      cfg_data = '0;

	gaussian_window_smoother #(
		.MAX_HALF_WIDTH(MAX_HW),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: the sample window (newest at position 0), the number of samples of
	// the open sequence seen so far, and a shadow copy of the configuration registers.
	logic signed [SAMPLE_W-1:0] taps [WIN_LEN];
	int unsigned                held_count;
	logic [HW_W-1:0]            cfg_half_width;
	logic [COEF_W-1:0]          weight [NUM_COEF];

	sample_req_t sample_queue [$];
	smooth_t     expected_smoothed [$];

	int queued_count   = 0;
	int accepted_count = 0;
	int result_count   = 0;
	int seq_count      = 0;
	int write_count    = 0;
	int error_count    = 0;

	// Set at the rising edge when a sample request was taken; read by the driver at the
	// following falling edge.
	logic in_taken = 1'b0;
	// Turns off all random idling on both sides for one stretch of the run.
	logic no_idle = 1'b0;

	smooth_t want;

	initial begin
		forever #2 clk = ~clk;
	end

	// Weighted sum centered on window position center, rounded half up to Q8.8 and
	// saturated to the sample range.
	function automatic logic [SAMPLE_W-1:0] weigh_at(int center, int hw);
		longint acc;
		longint rounded;
		longint top;
		longint bottom;
		int j;
		top = (longint'(1) << (SAMPLE_W - 1)) - 1;
		bottom = -top - 1;
		acc = longint'(taps[center]) * longint'(weight[0]);
		for (j = 1; j <= hw && j < NUM_COEF; j++) begin
			if (center >= j)
				acc += longint'(taps[center - j]) * longint'(weight[j]);
			if (center + j < WIN_LEN)
				acc += longint'(taps[center + j]) * longint'(weight[j]);
		end
		rounded = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		if (rounded > top)
			rounded = top;
		if (rounded < bottom)
			rounded = bottom;
		return rounded[SAMPLE_W-1:0];
	endfunction

	// Advances the predictor by one accepted sample and queues the results it releases.
	task automatic predict_sample(logic signed [SAMPLE_W-1:0] sample, logic seq_end);
		int hw;
		int held;
		int pending;
		int k;
		int i;
		smooth_t res;
		// A half width above the maximum acts as the maximum.
		hw = (cfg_half_width > MAX_HW) ? MAX_HW : int'(cfg_half_width);
		for (i = WIN_LEN - 1; i > 0; i--)
			taps[i] = taps[i - 1];
		taps[0] = sample;
		if (!seq_end) begin
			if (held_count < hw) begin
				held_count++;
			end else begin
				res.value = weigh_at(hw, hw);
				res.is_last = 1'b0;
				expected_smoothed.push_back(res);
			end
		end else begin
			// The sequence end flushes every pending center, oldest first.
			held = (held_count < hw) ? int'(held_count) : hw;
			pending = held + 1;
			for (k = 0; k < pending; k++) begin
				res.value = weigh_at(pending - 1 - k, hw);
				res.is_last = (k == pending - 1);
				expected_smoothed.push_back(res);
			end
			for (i = 0; i < WIN_LEN; i++)
				taps[i] = '0;
			held_count = 0;
		end
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic seq_end);
		sample_req_t req;
		req.sample = sample;
		req.seq_end = seq_end;
		sample_queue.push_back(req);
		queued_count++;
	endtask

	// Presents one register write and holds it until it is taken. Consecutive writes keep
	// cfg_valid high; close_writes lowers it afterwards.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_HALF_WIDTH)
			cfg_half_width = val[HW_W-1:0];
		else if (idx <= REG_COEF_DIST6)
			weight[idx - REG_COEF_CENTER] = val;
		write_count++;
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Holds the sender back until every queued sample is taken and every expected result
	// has come, then lets the pipeline settle so the block is idle for a register write.
	task automatic drain_and_settle();
		int waited;
		waited = 0;
		while ((accepted_count != queued_count || expected_smoothed.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			error_count++;
			$display("%0t: drain stuck, %0d results still expected, %0d samples not taken",
				$realtime, expected_smoothed.size(), queued_count - accepted_count);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sample driver: changes the request only at the falling edge, and keeps a request
	// stable until it has been taken.
	always @(negedge clk) begin : sample_driver
		sample_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (sample_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
				req = sample_queue.pop_front();
				s_tdata <= DATA_W'(req.sample);
				s_tlast <= req.seq_end;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, also at the falling edge.
	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Monitor: at each rising edge, feeds taken sample requests to the predictor and checks
	// each taken result against the oldest expectation.
	always @(posedge clk) begin
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken) begin
			predict_sample($signed(s_tdata[SAMPLE_W-1:0]), s_tlast);
			accepted_count++;
			if (s_tlast)
				seq_count++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (expected_smoothed.size() == 0) begin
				error_count++;
				$display("%0t: result with none expected, actual %0d last %0b",
					$realtime, $signed(m_tdata[SAMPLE_W-1:0]), m_tlast);
			end else begin
				want = expected_smoothed.pop_front();
				if (m_tdata[SAMPLE_W-1:0] !== want.value) begin
					error_count++;
					$display("%0t: smoothed mismatch, expected %0d actual %0d", $realtime,
						$signed(want.value), $signed(m_tdata[SAMPLE_W-1:0]));
				end
				if (m_tlast !== want.is_last) begin
					error_count++;
					$display("%0t: out_last mismatch, expected %0b actual %0b", $realtime,
						want.is_last, m_tlast);
				end
			end
		end
	end

	initial begin
		int phase;
		int hw;
		int wmode;
		int left;
		int len;
		int i;
		int k;
		logic cut;
		logic [COEF_W-1:0] w;
		logic [SAMPLE_W-1:0] smp;

		// The predictor starts from the register reset values: half width zero and a
		// unit center weight, which makes the block a pass-through.
		for (i = 0; i < WIN_LEN; i++)
			taps[i] = '0;
		held_count = 0;
		cfg_half_width = '0;
		weight[0] = COEF_CENTER_RESET;
		for (i = 1; i < NUM_COEF; i++)
			weight[i] = '0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset configuration: extremes of the sample range pass through unchanged.
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		// A sequence of a single sample gives a single result.
		send_sample(16'h1234, 1'b1);
		drain_and_settle();

		// Full window with the normalized Gaussian weights; every register is written.
		write_reg(REG_HALF_WIDTH, 17'd6);
		write_reg(REG_COEF_CENTER, 17'd10964);
		write_reg(REG_COEF_CENTER + 4'd1, 17'd10053);
		write_reg(REG_COEF_CENTER + 4'd2, 17'd7747);
		write_reg(REG_COEF_CENTER + 4'd3, 17'd5019);
		write_reg(REG_COEF_CENTER + 4'd4, 17'd2734);
		write_reg(REG_COEF_CENTER + 4'd5, 17'd1251);
		write_reg(REG_COEF_DIST6, 17'd481);
		// A write beyond the last register must leave everything as it was.
		write_reg(REG_COEF_DIST6 + 4'd1, 17'h1FFFF);
		close_writes();
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0100, 1'b0);
		send_sample(16'hFF00, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		drain_and_settle();

		// Half width above the maximum, and the largest weights, so both saturation
		// limits are reached.
		write_reg(REG_HALF_WIDTH, 17'd7);
		for (k = REG_COEF_CENTER; k <= REG_COEF_DIST6; k++)
			write_reg(CFG_INDEX_W'(k), 17'h1FFFF);
		close_writes();
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h8000, 1'b1);
		drain_and_settle();

		// Half width changed in the middle of an open sequence.
		write_reg(REG_HALF_WIDTH, 17'd2);
		close_writes();
		send_sample(16'h0400, 1'b0);
		send_sample(16'hFC00, 1'b0);
		send_sample(16'h2000, 1'b0);
		drain_and_settle();
		write_reg(REG_HALF_WIDTH, 17'd5);
		close_writes();
		send_sample(16'h0080, 1'b0);
		send_sample(16'hC000, 1'b0);
		send_sample(16'h5555, 1'b1);

		// Random phases. Each phase boundary holds the sender until every result is in,
		// then loads a new setting; a phase may end inside a sequence on purpose.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_and_settle();
			no_idle = (phase == STEADY_PHASE);
			if (phase == 0)
				hw = 0;
			else if (phase == 1)
				hw = 7;
			else if (phase == RANDOM_PHASES - 1)
				hw = MAX_HW;
			else
				hw = $urandom_range(0, 7);
			// Only the low bits of the half-width write count; the rest is random.
			write_reg(REG_HALF_WIDTH, COEF_W'(($urandom_range(0, 16383) << HW_W) | hw));
			wmode = $urandom_range(0, 3);
			for (k = REG_COEF_CENTER; k <= REG_COEF_DIST6; k++) begin
				case (wmode)
					0: w = COEF_W'($urandom_range(0, 65536 >> (k - REG_COEF_CENTER)));
					1: w = COEF_W'($urandom_range(0, 131071));
					2: w = COEF_W'($urandom_range(0, 65536));
					default: begin
						case ($urandom_range(0, 2))
							0: w = '0;
							1: w = 17'd65536;
							default: w = 17'h1FFFF;
						endcase
					end
				endcase
				write_reg(CFG_INDEX_W'(k), w);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_COEF_DIST6 + 4'd1 + 4'($urandom_range(0, 7)),
					COEF_W'($urandom_range(0, 131071)));
			close_writes();

			left = PHASE_ITEMS;
			while (left > 0) begin
				len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 18);
				cut = (len >= left) && ($urandom_range(0, 1) == 1);
				if (len > left)
					len = left;
				for (i = 0; i < len; i++) begin
					case ($urandom_range(0, 9))
						0: smp = 16'h7FFF;
						1: smp = 16'h8000;
						2, 3: smp = SAMPLE_W'($urandom_range(0, 1023) - 512);
						default: smp = SAMPLE_W'($urandom);
					endcase
					send_sample(smp, (i == len - 1) && !cut);
				end
				left -= len;
			end
		end

		drain_and_settle();
		no_idle = 1'b0;
		$display("Run covered %0d samples in %0d closed sequences, %0d results, %0d writes.",
			accepted_count, seq_count, result_count, write_count);
		$display("Half widths 0 to 7, weights up to the full 17 bits, idles on both sides.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
